/* sv/csfb_pkg.sv */
// Shared types and constants for the shift, flag and branch unit.
package csfb_pkg;

  // Command codes carried on the input word
  typedef enum logic [4:0] {
    CMD_ASL     = 5'd0,
    CMD_LSR     = 5'd1,
    CMD_ROL     = 5'd2,
    CMD_ROR     = 5'd3,
    CMD_CLC     = 5'd4,
    CMD_CLD     = 5'd5,
    CMD_CLI     = 5'd6,
    CMD_CLV     = 5'd7,
    CMD_SEC     = 5'd8,
    CMD_SED     = 5'd9,
    CMD_SEI     = 5'd10,
    CMD_BCC     = 5'd11,
    CMD_BCS     = 5'd12,
    CMD_BEQ     = 5'd13,
    CMD_BMI     = 5'd14,
    CMD_BNE     = 5'd15,
    CMD_BPL     = 5'd16,
    CMD_BVC     = 5'd17,
    CMD_BVS     = 5'd18,
    CMD_RESTORE = 5'd19,
    CMD_BRK     = 5'd20
  } cmd_t;

  // Status register bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // Status after reset: only the unused bit set
  localparam logic [7:0] STATUS_RESET = 8'h20;
  // Break and unused bits forced into a pushed status byte
  localparam logic [7:0] PUSH_MASK    = 8'h30;

  // One result word plus the updated status
  typedef struct packed {
    logic [7:0]  result_value;
    logic [15:0] next_pc;
    logic        branch_taken;
    logic        page_crossed;
    logic [7:0]  status_out;
  } result_t;

endpackage

/* sv/csfb_exec.sv */
// Combinational execute logic: shifts, flag changes, branches, restore and break.
module csfb_exec import csfb_pkg::*; (
  input  logic [4:0]        command,
  input  logic [7:0]        operand_value,
  input  logic [15:0]       current_pc,
  input  logic signed [7:0] branch_offset,
  input  logic [7:0]        status,
  output result_t           result
);

  logic        cond;
  logic        is_branch;
  logic [7:0]  shifted;
  logic [15:0] target_pc;

  // Branch target: sign-extend the displacement, wrap at 64K
  assign target_pc = current_pc + {{8{branch_offset[7]}}, branch_offset};

  // Evaluate the branch condition for the branch commands
  always_comb begin
    cond      = 1'b0;
    is_branch = 1'b1;
    unique case (command)
      CMD_BCC: cond = !status[FLAG_C];
      CMD_BCS: cond = status[FLAG_C];
      CMD_BEQ: cond = status[FLAG_Z];
      CMD_BMI: cond = status[FLAG_N];
      CMD_BNE: cond = !status[FLAG_Z];
      CMD_BPL: cond = !status[FLAG_N];
      CMD_BVC: cond = !status[FLAG_V];
      CMD_BVS: cond = status[FLAG_V];
      default: is_branch = 1'b0;
    endcase
  end

  // Decode the command and build the result word
  always_comb begin
    shifted             = 8'h00;
    result.result_value = 8'h00;
    result.next_pc      = current_pc;
    result.branch_taken = 1'b0;
    result.page_crossed = 1'b0;
    result.status_out   = status;
    unique case (command)
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        case (command)
          CMD_ASL: shifted = {operand_value[6:0], 1'b0};
          CMD_LSR: shifted = {1'b0, operand_value[7:1]};
          CMD_ROL: shifted = {operand_value[6:0], status[FLAG_C]};
          default: shifted = {status[FLAG_C], operand_value[7:1]};
        endcase
        result.result_value      = shifted;
        result.status_out[FLAG_C] = (command == CMD_ASL || command == CMD_ROL) ?
                                    operand_value[7] : operand_value[0];
        result.status_out[FLAG_Z] = (shifted == 8'h00);
        result.status_out[FLAG_N] = shifted[7];
      end
      CMD_CLC: result.status_out[FLAG_C] = 1'b0;
      CMD_CLD: result.status_out[FLAG_D] = 1'b0;
      CMD_CLI: result.status_out[FLAG_I] = 1'b0;
      CMD_CLV: result.status_out[FLAG_V] = 1'b0;
      CMD_SEC: result.status_out[FLAG_C] = 1'b1;
      CMD_SED: result.status_out[FLAG_D] = 1'b1;
      CMD_SEI: result.status_out[FLAG_I] = 1'b1;
      CMD_RESTORE: begin
        result.status_out         = operand_value;
        result.status_out[FLAG_U] = 1'b1;
      end
      CMD_BRK: begin
        result.result_value       = status | PUSH_MASK;
        result.status_out[FLAG_I] = 1'b1;
      end
      default: begin
        // Taken branches redirect the program counter; others fall through
        if (is_branch && cond) begin
          result.next_pc      = target_pc;
          result.branch_taken = 1'b1;
          result.page_crossed = (target_pc[15:8] != current_pc[15:8]);
        end
      end
    endcase
  end

endmodule

/* sv/cpu_shift_flag_branch_unit.sv */
// Top level of the shift, flag and branch unit with its status register.
//
// Takes one command word per cycle while in_stall is low and returns one
// result word per command. A word is accepted into an input register,
// executed by a short block of logic against the held status register, and
// written with the new status into the result register, which it enters
// once the result register is empty or being drained: one word per cycle
// sustained while out_stall is low. The status register is updated as each
// word moves into the result register, so every command sees the status left
// by the one before it. The status resets to 0x20 (only the unused bit set).
// Unknown command codes leave the status alone and return a zero result.
module cpu_shift_flag_branch_unit import csfb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [4:0]        in_command,
  input  logic [7:0]        in_operand_value,
  input  logic [15:0]       in_current_pc,
  input  logic signed [7:0] in_branch_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_result_value,
  output logic [15:0]       out_next_pc,
  output logic              out_branch_taken,
  output logic              out_page_crossed,
  output logic [7:0]        out_status_out
);

  logic              s1_valid_r;
  logic [4:0]        s1_command_r;
  logic [7:0]        s1_operand_r;
  logic [15:0]       s1_pc_r;
  logic signed [7:0] s1_offset_r;
  logic [7:0]        status_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           result_nxt;
  logic              advance;

  // Move a word on when the result register is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  csfb_exec u_exec (
    .command       (s1_command_r),
    .operand_value (s1_operand_r),
    .current_pc    (s1_pc_r),
    .branch_offset (s1_offset_r),
    .status        (status_r),
    .result        (result_nxt)
  );

  // Input register: load when not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_command_r <= in_command;
      s1_operand_r <= in_operand_value;
      s1_pc_r      <= in_current_pc;
      s1_offset_r  <= in_branch_offset;
    end
  end

  // Status register and result valid: advance with each executed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= STATUS_RESET;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      status_r    <= result_nxt.status_out;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_r.result_value;
  assign out_next_pc      = out_r.next_pc;
  assign out_branch_taken = out_r.branch_taken;
  assign out_page_crossed = out_r.page_crossed;
  assign out_status_out   = out_r.status_out;

endmodule
